[rtl/core/cbm_pkg.sv]
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, register addresses and the write decoder of the cartridge
// bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int AddrBits    = 16;
   localparam int DataBits    = 8;
   localparam int ChrWindows  = 8;
   localparam int ChrWinBits  = $clog2(ChrWindows);
   localparam int PrgWinBits  = 2;
   localparam int MirrorBits  = 2;

   // Address decode mask and the decoded register addresses.
   localparam logic [AddrBits-1:0] DecodeMask = 16'hF0CF;
   localparam logic [AddrBits-1:0] RegPrg0    = 16'h8000;
   localparam logic [AddrBits-1:0] RegMirror  = 16'h9000;
   localparam logic [AddrBits-1:0] RegSwapA   = 16'h9002;
   localparam logic [AddrBits-1:0] RegSwapB   = 16'h9080;
   localparam logic [AddrBits-1:0] RegPrg1    = 16'hA000;
   localparam logic [AddrBits-1:0] RegLatchLo = 16'hF000;
   localparam logic [AddrBits-1:0] RegLatchHi = 16'hF001;
   localparam logic [AddrBits-1:0] RegIrqCtrl = 16'hF002;
   localparam logic [AddrBits-1:0] RegIrqAck  = 16'hF003;

   // First and last 4K page that holds CHR bank registers.
   localparam logic [3:0] ChrPageFirst = 4'hB;
   localparam logic [3:0] ChrPageLast  = 4'hE;

   // PRG window codes.
   localparam logic [PrgWinBits-1:0] PrgWin8000 = 2'd0;
   localparam logic [PrgWinBits-1:0] PrgWinA000 = 2'd1;
   localparam logic [PrgWinBits-1:0] PrgWinC000 = 2'd2;

   localparam logic [DataBits-1:0] CountMax = 8'hFF;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TICK,
      OP_PRG0,
      OP_PRG1,
      OP_MIRROR,
      OP_SWAP,
      OP_CHR,
      OP_LATCH_LO,
      OP_LATCH_HI,
      OP_IRQ_CTRL,
      OP_IRQ_ACK
   } op_type;

   // Decoded form of one input item.
   typedef struct packed {
      op_type                op;
      logic [ChrWinBits-1:0] chr_win;
      logic                  chr_high;
   } cmd_type;

   // Status handed from the control registers to the result path.
   typedef struct packed {
      logic swap_c000;
      logic irq_level;
   } ctrl_status_type;

   // One result item.
   typedef struct packed {
      logic                  prg_update;
      logic [PrgWinBits-1:0] prg_window;
      logic [DataBits-1:0]   prg_bank;
      logic                  chr_update;
      logic [ChrWinBits-1:0] chr_window;
      logic [DataBits-1:0]   chr_bank;
      logic                  mirror_update;
      logic [MirrorBits-1:0] mirror_mode;
      logic                  irq_level;
   } rsp_type;

   // Turns an item into an operation code and the CHR window it targets.
   function automatic cmd_type decode(input logic kind, input logic [AddrBits-1:0] address);
      logic [AddrBits-1:0] dec;
      logic [3:0]          page;
      logic [3:0]          page_ofs;
      cmd_type             cmd;
      dec          = address & DecodeMask;
      page         = dec[15:12];
      page_ofs     = page - ChrPageFirst;
      cmd.op       = OP_NONE;
      cmd.chr_win  = {page_ofs[1:0], dec[1]};
      cmd.chr_high = dec[0];
      if (kind) begin
         cmd.op = OP_TICK;
      end else begin
         case (dec)
            RegPrg0:            cmd.op = OP_PRG0;
            RegPrg1:            cmd.op = OP_PRG1;
            RegMirror:          cmd.op = OP_MIRROR;
            RegSwapA, RegSwapB: cmd.op = OP_SWAP;
            RegLatchLo:         cmd.op = OP_LATCH_LO;
            RegLatchHi:         cmd.op = OP_LATCH_HI;
            RegIrqCtrl:         cmd.op = OP_IRQ_CTRL;
            RegIrqAck:          cmd.op = OP_IRQ_ACK;
            default: begin
               if (page inside {[ChrPageFirst:ChrPageLast]} && dec[7:0] <= 8'd3) begin
                  cmd.op = OP_CHR;
               end
            end
         endcase
      end
      return cmd;
   endfunction

endpackage

[rtl/core/cbm_channels.sv]
// ----------------------------------------------------------------------------
// cbm_channels
// Valid/ready channel interfaces for request and response items.
// ----------------------------------------------------------------------------
interface cbm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [cbm_pkg::AddrBits-1:0]  address;
   logic [cbm_pkg::DataBits-1:0]  write_data;

   modport source (output valid, output kind, output address, output write_data,
                   input ready);
   modport sink   (input valid, input kind, input address, input write_data,
                   output ready);
endinterface

interface cbm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            prg_update;
   logic [cbm_pkg::PrgWinBits-1:0]  prg_window;
   logic [cbm_pkg::DataBits-1:0]    prg_bank;
   logic                            chr_update;
   logic [cbm_pkg::ChrWinBits-1:0]  chr_window;
   logic [cbm_pkg::DataBits-1:0]    chr_bank;
   logic                            mirror_update;
   logic [cbm_pkg::MirrorBits-1:0]  mirror_mode;
   logic                            irq_level;

   modport source (output valid, output prg_update, output prg_window, output prg_bank,
                   output chr_update, output chr_window, output chr_bank,
                   output mirror_update, output mirror_mode, output irq_level,
                   input ready);
   modport sink   (input valid, input prg_update, input prg_window, input prg_bank,
                   input chr_update, input chr_window, input chr_bank,
                   input mirror_update, input mirror_mode, input irq_level,
                   output ready);
endinterface

[rtl/core/cbm_chr_mem.sv]
// ----------------------------------------------------------------------------
// cbm_chr_mem
// CHR bank register file: a small synchronous memory with registered read,
// per-entry valid bits for the reset contents and write-to-read forwarding.
// ----------------------------------------------------------------------------
module cbm_chr_mem #(
   parameter int Depth = cbm_pkg::ChrWindows,
   parameter int Width = cbm_pkg::DataBits
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   localparam int AddrW = $clog2(Depth);

   logic [Width-1:0] chr_mem [Depth];
   logic [Width-1:0] mem_rd_ff;
   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] valid_in;
   logic             entry_valid_ff;
   logic [AddrW-1:0] rd_addr_ff;
   logic             fwd_hit_ff;
   logic [Width-1:0] fwd_data_ff;

   // Memory array: write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         chr_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= chr_mem[rd_addr];
      end
   end

   // An entry becomes valid on its first write; until then it reads as its index.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // A read that meets a write to the same entry in the same cycle takes the new data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_addr_ff     <= rd_addr;
         entry_valid_ff <= valid_ff[rd_addr];
         fwd_hit_ff     <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff    <= wr_data;
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         rd_data = fwd_data_ff;
      end else if (entry_valid_ff) begin
         rd_data = mem_rd_ff;
      end else begin
         rd_data = Width'(rd_addr_ff);
      end
   end

endmodule

[rtl/core/cbm_irq_ctrl.sv]
// ----------------------------------------------------------------------------
// cbm_irq_ctrl
// Swap mode, IRQ latch, counter, enable bits and IRQ line, updated as each
// item leaves the execute stage.
// ----------------------------------------------------------------------------
module cbm_irq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  cbm_pkg::op_type              op,
   input  logic [cbm_pkg::DataBits-1:0] data,
   output cbm_pkg::ctrl_status_type     status
);

   logic                         swap_ff,   swap_in;
   logic [1:0]                   enable_ff, enable_in;
   logic [cbm_pkg::DataBits-1:0] count_ff,  count_in;
   logic [cbm_pkg::DataBits-1:0] reload_ff, reload_in;
   logic                         line_ff,   line_in;

   // Next-state logic for the item in the execute stage.
   always_comb begin
      swap_in   = swap_ff;
      enable_in = enable_ff;
      count_in  = count_ff;
      reload_in = reload_ff;
      line_in   = line_ff;
      case (op)
         cbm_pkg::OP_TICK: begin
            if (enable_ff[1]) begin
               if (count_ff == cbm_pkg::CountMax) begin
                  count_in = reload_ff;
                  line_in  = 1'b1;
               end else begin
                  count_in = count_ff + 8'd1;
               end
            end
         end
         cbm_pkg::OP_SWAP: swap_in = data[1];
         cbm_pkg::OP_LATCH_LO: begin
            reload_in = {reload_ff[7:4], data[3:0]};
            line_in   = 1'b0;
         end
         cbm_pkg::OP_LATCH_HI: begin
            reload_in = {data[3:0], reload_ff[3:0]};
            line_in   = 1'b0;
         end
         cbm_pkg::OP_IRQ_CTRL: begin
            enable_in = data[1:0];
            if (data[1]) begin
               count_in = reload_ff;
            end
            line_in = 1'b0;
         end
         cbm_pkg::OP_IRQ_ACK: begin
            enable_in = {enable_ff[0], enable_ff[0]};
            line_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff   <= 1'b0;
         enable_ff <= '0;
         count_ff  <= '0;
         reload_ff <= '0;
         line_ff   <= 1'b0;
      end else if (fire) begin
         swap_ff   <= swap_in;
         enable_ff <= enable_in;
         count_ff  <= count_in;
         reload_ff <= reload_in;
         line_ff   <= line_in;
      end
   end

   // The swap bit is read before this item's update; the IRQ level after it.
   assign status.swap_c000 = swap_ff;
   assign status.irq_level = line_in;

endmodule

[rtl/core/cartridge_bank_mapper_irq_core.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_core
// Cartridge bank mapper with scanline IRQ counter.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one item per handshake: a CPU write (kind 0, address and
//   write_data) or a scanline tick (kind 1). rsp_if returns exactly one
//   result item per request item, in order: PRG, CHR and mirroring updates
//   and the IRQ level after the item.
//   The request item and its CHR bank memory read are registered on
//   acceptance; the execute stage then merges the nibble, writes the entry
//   back and registers the result in the result register. Throughput is one
//   item per cycle while the receiver takes each result; back-to-back writes
//   to the same CHR entry are served by forwarding from the write port.
//   Reset clears all mapper registers and the CHR valid bits at once, so
//   each CHR window reads as its own index until written; no clearing pass.
//   When the receiver stalls, the result register holds, the execute stage
//   keeps one more item, and req_if.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_core (
   input  logic      clock,
   input  logic      reset,
   cbm_req_if.sink   req_if,
   cbm_rsp_if.source rsp_if
);

   logic                         req_fire;
   logic                         s1_fire;
   logic                         s1_valid_ff;
   cbm_pkg::cmd_type             cmd_in;
   cbm_pkg::cmd_type             s1_cmd_ff;
   logic [cbm_pkg::DataBits-1:0] s1_data_ff;
   logic [cbm_pkg::DataBits-1:0] chr_cur;
   logic [cbm_pkg::DataBits-1:0] chr_new;
   logic                         chr_wr;
   cbm_pkg::ctrl_status_type     status;
   cbm_pkg::rsp_type             rsp_in;
   cbm_pkg::rsp_type             rsp_ff;
   logic                         rsp_valid_ff;

   // Handshake: the execute stage advances when the result register frees up.
   assign s1_fire       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || s1_fire;
   assign req_fire      = req_if.valid && req_if.ready;
   assign cmd_in        = cbm_pkg::decode(req_if.kind, req_if.address);

   // Execute stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= cmd_in;
         s1_data_ff <= req_if.write_data;
      end
   end

   // CHR bank memory, read on acceptance and written back from execute.
   assign chr_wr = s1_fire && (s1_cmd_ff.op == cbm_pkg::OP_CHR);

   cbm_chr_mem #(
      .Depth (cbm_pkg::ChrWindows),
      .Width (cbm_pkg::DataBits)
   ) u_chr_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (cmd_in.chr_win),
      .wr_en   (chr_wr),
      .wr_addr (s1_cmd_ff.chr_win),
      .wr_data (chr_new),
      .rd_data (chr_cur)
   );

   // Nibble merge: data bits 3..0 land in the high or low half.
   assign chr_new = s1_cmd_ff.chr_high ? {s1_data_ff[3:0], chr_cur[3:0]}
                                       : {chr_cur[7:4], s1_data_ff[3:0]};

   cbm_irq_ctrl u_irq_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .op     (s1_cmd_ff.op),
      .data   (s1_data_ff),
      .status (status)
   );

   // Result assembly; fields of groups that were not updated stay zero.
   always_comb begin
      rsp_in           = '0;
      rsp_in.irq_level = status.irq_level;
      case (s1_cmd_ff.op)
         cbm_pkg::OP_PRG0: begin
            rsp_in.prg_update = 1'b1;
            rsp_in.prg_window = status.swap_c000 ? cbm_pkg::PrgWinC000
                                                 : cbm_pkg::PrgWin8000;
            rsp_in.prg_bank   = s1_data_ff;
         end
         cbm_pkg::OP_PRG1: begin
            rsp_in.prg_update = 1'b1;
            rsp_in.prg_window = cbm_pkg::PrgWinA000;
            rsp_in.prg_bank   = s1_data_ff;
         end
         cbm_pkg::OP_MIRROR: begin
            rsp_in.mirror_update = 1'b1;
            rsp_in.mirror_mode   = s1_data_ff[1:0];
         end
         cbm_pkg::OP_CHR: begin
            rsp_in.chr_update = 1'b1;
            rsp_in.chr_window = s1_cmd_ff.chr_win;
            rsp_in.chr_bank   = chr_new;
         end
         default: begin
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.prg_update    = rsp_ff.prg_update;
   assign rsp_if.prg_window    = rsp_ff.prg_window;
   assign rsp_if.prg_bank      = rsp_ff.prg_bank;
   assign rsp_if.chr_update    = rsp_ff.chr_update;
   assign rsp_if.chr_window    = rsp_ff.chr_window;
   assign rsp_if.chr_bank      = rsp_ff.chr_bank;
   assign rsp_if.mirror_update = rsp_ff.mirror_update;
   assign rsp_if.mirror_mode   = rsp_ff.mirror_mode;
   assign rsp_if.irq_level     = rsp_ff.irq_level;

endmodule

[rtl/core/cbm_checker.sv]
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the bank mapper core, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           prg_update,
   input logic [cbm_pkg::PrgWinBits-1:0] prg_window,
   input logic [cbm_pkg::DataBits-1:0]   prg_bank,
   input logic                           chr_update,
   input logic [cbm_pkg::ChrWinBits-1:0] chr_window,
   input logic [cbm_pkg::DataBits-1:0]   chr_bank,
   input logic                           mirror_update,
   input logic [cbm_pkg::MirrorBits-1:0] mirror_mode
);

   // A stalled result item keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({prg_update, prg_window, prg_bank,
         chr_update, chr_window, chr_bank, mirror_update, mirror_mode}))
      else $error("result item changed while stalled");

   // One item updates at most one group.
   a_one_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({prg_update, chr_update, mirror_update}))
      else $error("more than one update group in a result item");

   // Fields of a group that was not updated are zero.
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (prg_update || (prg_window == '0 && prg_bank == '0)) &&
                    (chr_update || (chr_window == '0 && chr_bank == '0)) &&
                    (mirror_update || mirror_mode == '0))
      else $error("unused result fields are not zero");

   // The PRG window code never names the fixed last window.
   a_prg_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && prg_update |-> prg_window != 2'd3)
      else $error("invalid PRG window");

endmodule

bind cartridge_bank_mapper_irq_core cbm_checker u_cbm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .prg_update    (rsp_if.prg_update),
   .prg_window    (rsp_if.prg_window),
   .prg_bank      (rsp_if.prg_bank),
   .chr_update    (rsp_if.chr_update),
   .chr_window    (rsp_if.chr_window),
   .chr_bank      (rsp_if.chr_bank),
   .mirror_update (rsp_if.mirror_update),
   .mirror_mode   (rsp_if.mirror_mode)
);

[tb/tb_cartridge_bank_mapper_irq_core.sv]
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_irq_core
// Self-checking testbench for the cartridge bank mapper with scanline IRQ.
// A behavioral model of the mapper registers and the IRQ counter predicts
// one response per request item. Directed tests cover PRG, mirroring, swap,
// CHR nibble loads, undecoded writes and the IRQ counter. Random phases then
// mix decoded writes with address alias bits, ticks and noise, under
// changing idle rates on both channels.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_irq_core;

   logic clock;
   logic reset;

   cbm_req_if req_if ();
   cbm_rsp_if rsp_if ();

   cartridge_bank_mapper_irq_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Model state of the mapper.
   logic [cbm_pkg::DataBits-1:0] chr_bank_regs [cbm_pkg::ChrWindows];
   logic [cbm_pkg::DataBits-1:0] swap_reg;
   logic [1:0]                   irq_enable_reg;
   logic [cbm_pkg::DataBits-1:0] model_count;
   logic [cbm_pkg::DataBits-1:0] model_reload;
   logic                         irq_out;

   cbm_pkg::rsp_type pending_responses [$];
   int               mismatch_count = 0;
   int               send_idle_pct;
   int               recv_idle_pct;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit, far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver side: ready is dropped at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Puts the model back into its reset state.
   task automatic reset_mapper_state();
      for (int i = 0; i < cbm_pkg::ChrWindows; i++) begin
         chr_bank_regs[i] = cbm_pkg::DataBits'(i);
      end
      swap_reg       = '0;
      irq_enable_reg = '0;
      model_count    = '0;
      model_reload   = '0;
      irq_out        = 1'b0;
   endtask

   // Applies one item to the model and returns the response it causes.
   function automatic cbm_pkg::rsp_type next_mapper_response(
         input logic                         kind,
         input logic [cbm_pkg::AddrBits-1:0] address,
         input logic [cbm_pkg::DataBits-1:0] data);
      cbm_pkg::rsp_type             resp;
      logic [cbm_pkg::AddrBits-1:0] dec;
      logic [3:0]                   page;
      logic [3:0]                   page_ofs;
      logic [2:0]                   win;
      resp = '0;
      if (kind) begin
         // Scanline tick: count while enabled, reload and raise IRQ on overflow.
         if (irq_enable_reg[1]) begin
            if (model_count == cbm_pkg::CountMax) begin
               model_count = model_reload;
               irq_out     = 1'b1;
            end else begin
               model_count = model_count + 8'd1;
            end
         end
      end else begin
         dec = address & cbm_pkg::DecodeMask;
         case (dec)
            cbm_pkg::RegPrg0: begin
               resp.prg_update = 1'b1;
               resp.prg_window = swap_reg[1] ? cbm_pkg::PrgWinC000 : cbm_pkg::PrgWin8000;
               resp.prg_bank   = data;
            end
            cbm_pkg::RegPrg1: begin
               resp.prg_update = 1'b1;
               resp.prg_window = cbm_pkg::PrgWinA000;
               resp.prg_bank   = data;
            end
            cbm_pkg::RegMirror: begin
               resp.mirror_update = 1'b1;
               resp.mirror_mode   = data[1:0];
            end
            cbm_pkg::RegSwapA, cbm_pkg::RegSwapB: begin
               swap_reg = data;
            end
            cbm_pkg::RegLatchLo: begin
               model_reload[3:0] = data[3:0];
               irq_out           = 1'b0;
            end
            cbm_pkg::RegLatchHi: begin
               model_reload[7:4] = data[3:0];
               irq_out           = 1'b0;
            end
            cbm_pkg::RegIrqCtrl: begin
               irq_enable_reg = data[1:0];
               if (irq_enable_reg[1]) begin
                  model_count = model_reload;
               end
               irq_out = 1'b0;
            end
            cbm_pkg::RegIrqAck: begin
               irq_enable_reg = {irq_enable_reg[0], irq_enable_reg[0]};
               irq_out        = 1'b0;
            end
            default: begin
               // CHR registers: two per 4K page, low or high nibble by bit 0.
               page = dec[15:12];
               if (page inside {[cbm_pkg::ChrPageFirst:cbm_pkg::ChrPageLast]} &&
                   dec[7:0] <= 8'd3) begin
                  page_ofs = page - cbm_pkg::ChrPageFirst;
                  win      = {page_ofs[1:0], dec[1]};
                  if (dec[0]) begin
                     chr_bank_regs[win][7:4] = data[3:0];
                  end else begin
                     chr_bank_regs[win][3:0] = data[3:0];
                  end
                  resp.chr_update = 1'b1;
                  resp.chr_window = win;
                  resp.chr_bank   = chr_bank_regs[win];
               end
            end
         endcase
      end
      resp.irq_level = irq_out;
      return resp;
   endfunction

   // Sends one item; the expected response is queued when valid goes up.
   task automatic send_item(input logic kind, input logic [cbm_pkg::AddrBits-1:0] address,
                            input logic [cbm_pkg::DataBits-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      pending_responses.push_back(next_mapper_response(kind, address, data));
      req_if.valid      <= 1'b1;
      req_if.kind       <= kind;
      req_if.address    <= address;
      req_if.write_data <= data;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
   endtask

   // Holds the sender off until every expected response has arrived.
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   // Adds random values to the address bits that the decoder ignores.
   function automatic logic [cbm_pkg::AddrBits-1:0] alias_of(
         input logic [cbm_pkg::AddrBits-1:0] base);
      logic [cbm_pkg::AddrBits-1:0] noise;
      noise = cbm_pkg::AddrBits'($urandom);
      return base | (noise & ~cbm_pkg::DecodeMask);
   endfunction

   // Compares one field of a response and reports the first mismatches.
   task automatic check_field(input string field_name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         if (mismatch_count < 10) begin
            $display("mismatch in %s: expected %0h, actual %0h", field_name, want, got);
         end
         mismatch_count++;
      end
   endtask

   // Response checker: every accepted item is compared with the oldest prediction.
   always @(posedge clock) begin : response_checker
      cbm_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_responses.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("response item arrived with nothing expected");
            end
            mismatch_count++;
         end else begin
            want = pending_responses.pop_front();
            check_field("prg_update", 32'(want.prg_update), 32'(rsp_if.prg_update));
            check_field("prg_window", 32'(want.prg_window), 32'(rsp_if.prg_window));
            check_field("prg_bank", 32'(want.prg_bank), 32'(rsp_if.prg_bank));
            check_field("chr_update", 32'(want.chr_update), 32'(rsp_if.chr_update));
            check_field("chr_window", 32'(want.chr_window), 32'(rsp_if.chr_window));
            check_field("chr_bank", 32'(want.chr_bank), 32'(rsp_if.chr_bank));
            check_field("mirror_update", 32'(want.mirror_update),
                        32'(rsp_if.mirror_update));
            check_field("mirror_mode", 32'(want.mirror_mode), 32'(rsp_if.mirror_mode));
            check_field("irq_level", 32'(want.irq_level), 32'(rsp_if.irq_level));
         end
      end
   end

   // PRG bank selects, the swap mode through both addresses, and mirroring.
   task automatic test_prg_and_mirroring();
      send_item(1'b0, cbm_pkg::RegPrg0, 8'hFF);
      send_item(1'b0, cbm_pkg::RegPrg1, 8'h00);
      send_item(1'b0, alias_of(cbm_pkg::RegSwapA), 8'h02);
      send_item(1'b0, alias_of(cbm_pkg::RegPrg0), 8'hA5);
      send_item(1'b0, cbm_pkg::RegSwapB, 8'hFD);
      send_item(1'b0, cbm_pkg::RegPrg0, 8'h3C);
      send_item(1'b0, alias_of(cbm_pkg::RegMirror), 8'hFF);
      send_item(1'b0, cbm_pkg::RegMirror, 8'h00);
   endtask

   // CHR nibble loads; the upper data bits must be dropped.
   task automatic test_chr_nibbles();
      send_item(1'b0, 16'hB000, 8'hFF);
      send_item(1'b0, 16'hE003, 8'hF7);
      send_item(1'b0, alias_of(16'hC001), 8'h3C);
      send_item(1'b0, 16'hD002, 8'h00);
   endtask

   // Writes that match no register change nothing.
   task automatic test_undecoded_writes();
      send_item(1'b0, 16'hFFFF, 8'hFF);
      send_item(1'b0, 16'h0000, 8'h00);
      send_item(1'b0, 16'hB004, 8'h5A);
      send_item(1'b0, 16'h9001, 8'h03);
   endtask

   // IRQ counter: latch load, enable, overflow, overflow while asserted,
   // acknowledge, and ticks while disabled.
   task automatic test_irq_counter();
      send_item(1'b0, cbm_pkg::RegLatchLo, 8'hFE);
      send_item(1'b0, cbm_pkg::RegLatchHi, 8'hFF);
      send_item(1'b0, cbm_pkg::RegIrqCtrl, 8'h03);
      repeat (4) send_item(1'b1, 16'hFFFF, 8'hFF);
      send_item(1'b0, cbm_pkg::RegIrqAck, 8'h00);
      send_item(1'b0, cbm_pkg::RegIrqCtrl, 8'h00);
      send_item(1'b1, 16'h0000, 8'h00);
   endtask

   // One random item: mostly decoded writes and ticks, some noise.
   task automatic send_random_item();
      logic [cbm_pkg::DataBits-1:0] data;
      logic [3:0]                   page;
      logic [1:0]                   low;
      data = cbm_pkg::DataBits'($urandom_range(255));
      case ($urandom_range(9))
         0, 1, 2, 3: send_item(1'b1, cbm_pkg::AddrBits'($urandom), data);
         4: send_item(1'b0, alias_of($urandom_range(1) ? cbm_pkg::RegPrg0
                                                       : cbm_pkg::RegPrg1), data);
         5: begin
            case ($urandom_range(2))
               0: send_item(1'b0, alias_of(cbm_pkg::RegMirror), data);
               1: send_item(1'b0, alias_of(cbm_pkg::RegSwapA), data);
               default: send_item(1'b0, alias_of(cbm_pkg::RegSwapB), data);
            endcase
         end
         6: begin
            page = 4'($urandom_range(cbm_pkg::ChrPageLast, cbm_pkg::ChrPageFirst));
            low  = 2'($urandom_range(3));
            send_item(1'b0, alias_of({page, 10'd0, low}), data);
         end
         7: begin
            // A high latch keeps overflows frequent.
            if ($urandom_range(1)) begin
               send_item(1'b0, alias_of(cbm_pkg::RegLatchLo), data);
            end else begin
               if ($urandom_range(3) != 0) begin
                  data[3:0] = 4'hF;
               end
               send_item(1'b0, alias_of(cbm_pkg::RegLatchHi), data);
            end
         end
         8: begin
            if ($urandom_range(1)) begin
               if ($urandom_range(3) != 0) begin
                  data[1] = 1'b1;
               end
               send_item(1'b0, alias_of(cbm_pkg::RegIrqCtrl), data);
            end else begin
               send_item(1'b0, alias_of(cbm_pkg::RegIrqAck), data);
            end
         end
         default: send_item(1'b0, cbm_pkg::AddrBits'($urandom), data);
      endcase
   endtask

   // A random phase under the given idle rates, drained at its end.
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_random_item();
      drain_responses();
   endtask

   // Main sequence.
   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.kind       = 1'b0;
      req_if.address    = '0;
      req_if.write_data = '0;
      send_idle_pct     = 10;
      recv_idle_pct     = 10;
      reset_mapper_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_prg_and_mirroring();
      test_chr_nibbles();
      test_undecoded_writes();
      test_irq_counter();
      drain_responses();

      test_random_traffic(24, 68, 250);
      test_random_traffic(68, 24, 250);
      test_random_traffic(0, 0, 250);

      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
